// ===== src/shadow_sprite_table_assert.svh =====
// Assertion macros for the shadow sprite table.
`ifndef SHADOW_SPRITE_TABLE_ASSERT_SVH
`define SHADOW_SPRITE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define SST_ASSERT(lbl, c, r, p, m) \
    lbl: assert property (@(posedge c) disable iff (!r) (p)) else $error(m);
`define SST_ASSERT_IMP(lbl, c, r, a, b, m) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error(m);
`else
`define SST_ASSERT(lbl, c, r, p, m)
`define SST_ASSERT_IMP(lbl, c, r, a, b, m)
`endif

`endif

// ===== src/sst_pkg.sv =====
// Shared types and constants for the shadow sprite table.
`default_nettype none

package sst_pkg;

    localparam int SLOTS    = 64;
    localparam int EMIT_MAX = 64;
    localparam int EMIT_LIM = (SLOTS < EMIT_MAX) ? SLOTS : EMIT_MAX;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MARK_W   = $clog2(SLOTS + 1);
    localparam int IDX_W    = $clog2(EMIT_LIM + 1);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [2:0] OP_BEGIN      = 3'd0;
    localparam logic [2:0] OP_PUT        = 3'd1;
    localparam logic [2:0] OP_HIDE       = 3'd2;
    localparam logic [2:0] OP_FLUSH      = 3'd3;
    localparam logic [2:0] OP_FLUSH_PART = 3'd4;
    localparam logic [2:0] OP_HIDE_ALL   = 3'd5;

    localparam logic [1:0] KIND_FULL     = 2'd0;
    localparam logic [1:0] KIND_ATTR     = 2'd1;
    localparam logic [1:0] KIND_ATTR_PAL = 2'd2;

    localparam logic [7:0] PRIO_MASK = 8'h18;

    typedef enum logic [2:0] {
        CMD_BEGIN,
        CMD_PUT,
        CMD_HIDE,
        CMD_FLUSH,
        CMD_FLUSH_PART,
        CMD_HIDE_ALL
    } cmd_op_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] slot;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [8:0] tile;
        logic [7:0] flags;
        logic [3:0] palette;
    } in_item_t;

    typedef struct packed {
        logic [5:0] entry_slot;
        logic [7:0] tile_low;
        logic [7:0] attr_byte;
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [3:0] out_palette;
        logic [1:0] write_kind;
        logic       last;
        logic [6:0] used_count;
    } result_t;

    typedef struct packed {
        logic [7:0] tile_low;
        logic [7:0] attr;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] pal;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        cmd_op_t             op;
        logic [SLOT_W-1:0]   slot;
        entry_t              entry;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

// ===== src/sst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/sst_front.sv =====
// Front end: item intake, priority register and command classification.
`default_nettype none

module sst_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sst_pkg::in_item_t item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    input  sst_pkg::q_status_t q_status,
    output logic              push,
    output sst_pkg::cmd_t     cmd
);
    import sst_pkg::*;

    logic [1:0] prio_reg;
    logic [1:0] prio_next;
    logic       slot_ok;
    logic       keep;
    logic [7:0] attr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        prio_next = prio_reg;
        if (cfg_valid && cfg_ready)
        begin
            prio_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg <= 2'd3;
        end
        else
        begin
            prio_reg <= prio_next;
        end
    end

    always_comb
    begin
        slot_ok = ({1'b0, item.slot} < 9'(SLOTS));
        attr    = item.flags;
        if ((attr & PRIO_MASK) == 8'h00)
        begin
            attr[4:3] = prio_reg;
        end
        attr[0] = attr[0] | item.tile[8];

        cmd.slot           = item.slot[SLOT_W-1:0];
        cmd.entry.tile_low = item.tile[7:0];
        cmd.entry.attr     = attr;
        cmd.entry.x        = item.x_pos;
        cmd.entry.y        = item.y_pos;
        cmd.entry.pal      = item.palette;

        unique case (item.op)
            OP_BEGIN:
            begin
                cmd.op = CMD_BEGIN;
                keep   = 1'b1;
            end
            OP_PUT:
            begin
                cmd.op = CMD_PUT;
                keep   = slot_ok;
            end
            OP_HIDE:
            begin
                cmd.op = CMD_HIDE;
                keep   = slot_ok;
            end
            OP_FLUSH:
            begin
                cmd.op = CMD_FLUSH;
                keep   = 1'b1;
            end
            OP_FLUSH_PART:
            begin
                cmd.op = CMD_FLUSH_PART;
                keep   = 1'b1;
            end
            OP_HIDE_ALL:
            begin
                cmd.op = CMD_HIDE_ALL;
                keep   = 1'b1;
            end
            default:
            begin
                cmd.op = CMD_BEGIN;
                keep   = 1'b0;
            end
        endcase

        push = start && !q_status.full && keep;
    end

endmodule

`default_nettype wire

// ===== src/sst_queue.sv =====
// Short command queue between front and back end.
`default_nettype none

module sst_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sst_pkg::cmd_t      wdata,
    input  logic               pop,
    output sst_pkg::cmd_t      rdata,
    output sst_pkg::q_status_t status
);
    import sst_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign rdata        = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sst_back.sv =====
// Back end: entry store, marks and run sequencer that streams entries.
`default_nettype none

module sst_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sst_pkg::q_status_t q_status,
    input  sst_pkg::cmd_t      q_cmd,
    output logic               pop,
    output logic               strobe,
    output sst_pkg::result_t   result
);
    import sst_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t             state_reg,     state_next;
    logic [MARK_W-1:0]  used_reg,      used_next;
    logic [MARK_W-1:0]  prev_reg,      prev_next;
    logic [SLOTS-1:0]   live_reg,      live_next;
    logic [SLOTS-1:0]   written_reg,   written_next;
    cmd_op_t            run_op_reg,    run_op_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic [IDX_W-1:0]   total_reg,     total_next;
    logic [IDX_W-1:0]   lo_reg,        lo_next;
    logic               rd_valid_reg,  rd_valid_next;
    logic [IDX_W-1:0]   rd_slot_reg,   rd_slot_next;
    logic [1:0]         rd_kind_reg,   rd_kind_next;
    logic               rd_last_reg,   rd_last_next;
    logic               rd_live_reg,   rd_live_next;
    logic               rd_wr_reg,     rd_wr_next;
    logic               strobe_reg,    strobe_next;
    result_t            result_reg,    result_next;

    logic [SLOT_W-1:0]  raddr;
    entry_t             rdata;
    logic               we;
    logic [MARK_W-1:0]  slot_p1;
    logic [IDX_W-1:0]   lo_used;
    logic [IDX_W-1:0]   lo_prev;

    function automatic logic [IDX_W-1:0] lim_of(input logic [MARK_W-1:0] mark);
        logic [IDX_W-1:0] r;
        if (int'(mark) < EMIT_LIM)
        begin
            r = IDX_W'(mark);
        end
        else
        begin
            r = IDX_W'(EMIT_LIM);
        end
        return r;
    endfunction

    assign pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign we     = pop && (q_cmd.op == CMD_PUT);
    assign raddr  = SLOT_W'(idx_reg);
    assign strobe = strobe_reg;
    assign result = result_reg;

    sst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (q_cmd.slot),
        .wdata (q_cmd.entry),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        prev_next     = prev_reg;
        live_next     = live_reg;
        written_next  = written_reg;
        run_op_next   = run_op_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        lo_next       = lo_reg;
        rd_valid_next = 1'b0;
        rd_slot_next  = idx_reg;
        rd_kind_next  = KIND_FULL;
        rd_last_next  = 1'b0;
        rd_live_next  = live_reg[raddr];
        rd_wr_next    = written_reg[raddr];
        slot_p1       = MARK_W'(q_cmd.slot) + MARK_W'(1);
        lo_used       = lim_of(used_reg);
        lo_prev       = lim_of(prev_reg);

        if (pop)
        begin
            unique case (q_cmd.op)
                CMD_BEGIN:
                begin
                    prev_next = used_reg;
                    used_next = '0;
                end
                CMD_PUT:
                begin
                    written_next[q_cmd.slot] = 1'b1;
                    live_next[q_cmd.slot]    = 1'b1;
                    if (slot_p1 > used_reg)
                    begin
                        used_next = slot_p1;
                    end
                end
                CMD_HIDE:
                begin
                    live_next[q_cmd.slot] = 1'b0;
                end
                CMD_FLUSH:
                begin
                    // stale tail of last frame goes hidden before streaming
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if ((MARK_W'(i) >= used_reg) && (MARK_W'(i) < prev_reg))
                        begin
                            live_next[i] = 1'b0;
                        end
                    end
                    run_op_next = CMD_FLUSH;
                    idx_next    = '0;
                    total_next  = IDX_W'(EMIT_LIM);
                    state_next  = ST_RUN;
                end
                CMD_FLUSH_PART:
                begin
                    run_op_next = CMD_FLUSH_PART;
                    idx_next    = '0;
                    lo_next     = lo_used;
                    total_next  = (lo_prev > lo_used) ? lo_prev : lo_used;
                    if ((lo_prev != '0) || (lo_used != '0))
                    begin
                        state_next = ST_RUN;
                    end
                end
                CMD_HIDE_ALL:
                begin
                    used_next   = '0;
                    prev_next   = '0;
                    run_op_next = CMD_HIDE_ALL;
                    idx_next    = '0;
                    total_next  = IDX_W'(EMIT_LIM);
                    state_next  = ST_RUN;
                end
                default:
                begin
                end
            endcase
        end

        if (state_reg == ST_RUN)
        begin
            rd_valid_next = 1'b1;
            rd_last_next  = ((idx_reg + IDX_W'(1)) == total_reg);
            case (run_op_reg)
                CMD_HIDE_ALL:   rd_kind_next = KIND_ATTR;
                CMD_FLUSH_PART: rd_kind_next = (idx_reg < lo_reg) ? KIND_FULL : KIND_ATTR_PAL;
                default:        rd_kind_next = KIND_FULL;
            endcase
            idx_next = idx_reg + IDX_W'(1);
            if (rd_last_next)
            begin
                state_next = ST_IDLE;
            end
        end

        strobe_next             = rd_valid_reg;
        result_next             = '0;
        result_next.entry_slot  = 6'(rd_slot_reg);
        result_next.write_kind  = rd_kind_reg;
        result_next.last        = rd_last_reg;
        result_next.used_count  = 7'(used_reg);
        if ((rd_kind_reg == KIND_FULL) && rd_wr_reg)
        begin
            result_next.tile_low    = rdata.tile_low;
            result_next.attr_byte   = rd_live_reg ? rdata.attr : 8'h00;
            result_next.out_x       = rdata.x;
            result_next.out_y       = rdata.y;
            result_next.out_palette = rdata.pal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            prev_reg     <= '0;
            live_reg     <= '0;
            written_reg  <= '0;
            run_op_reg   <= CMD_FLUSH;
            idx_reg      <= '0;
            total_reg    <= '0;
            lo_reg       <= '0;
            rd_valid_reg <= 1'b0;
            rd_slot_reg  <= '0;
            rd_kind_reg  <= KIND_FULL;
            rd_last_reg  <= 1'b0;
            rd_live_reg  <= 1'b0;
            rd_wr_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            prev_reg     <= prev_next;
            live_reg     <= live_next;
            written_reg  <= written_next;
            run_op_reg   <= run_op_next;
            idx_reg      <= idx_next;
            total_reg    <= total_next;
            lo_reg       <= lo_next;
            rd_valid_reg <= rd_valid_next;
            rd_slot_reg  <= rd_slot_next;
            rd_kind_reg  <= rd_kind_next;
            rd_last_reg  <= rd_last_next;
            rd_live_reg  <= rd_live_next;
            rd_wr_reg    <= rd_wr_next;
            strobe_reg   <= strobe_next;
            result_reg   <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/shadow_sprite_table.sv =====
// Top level of the shadow sprite table.
//
//  channel   handshake                    payload
//  item      start, busy (taken: start & !busy)  item   (sst_pkg::in_item_t)
//  result    strobe, one cycle, no stall  result (sst_pkg::result_t)
//  config    cfg_valid, cfg_ready         cfg_data (promote priority)
//
// begin, put and hide are handled in the back end; one item per cycle while busy is low.
// A flush run streams one entry per cycle from the store RAM, up to 64 entries;
// results pass the queue, run state, read stage and result register.
// busy rises while a run drains and the two-deep command queue is full.
// Reset clears the store through per-entry written/visible flags, no sweep.
`default_nettype none

`include "shadow_sprite_table_assert.svh"

module shadow_sprite_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sst_pkg::in_item_t item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    output logic              strobe,
    output sst_pkg::result_t  result
);
    import sst_pkg::*;

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    assign busy = q_status.full;

    sst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .cmd       (push_cmd)
    );

    sst_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (push_cmd),
        .pop    (pop),
        .rdata  (pop_cmd),
        .status (q_status)
    );

    sst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_cmd    (pop_cmd),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

    `SST_ASSERT_IMP(a_slot_range, clk, rst_n, strobe, int'(result.entry_slot) < EMIT_LIM, "slot beyond emit limit")
    `SST_ASSERT_IMP(a_run_contig, clk, rst_n, $past(strobe) && !$past(result.last), strobe && (result.entry_slot == 6'($past(result.entry_slot) + 6'd1)), "run broken")
    `SST_ASSERT_IMP(a_hide_all_marks, clk, rst_n, strobe && (result.write_kind == KIND_ATTR), result.used_count == 7'd0, "hide all left marks")

endmodule

`default_nettype wire

// ===== dv/shadow_sprite_table_tb.sv =====
// Self-checking testbench for the shadow sprite table: directed and random frames.
`timescale 1ns / 1ps

module shadow_sprite_table_tb;

    import sst_pkg::*;

    localparam int         CLK_HALF      = 4;
    localparam int         RESET_CYCLES  = 4;
    localparam int         RANDOM_ITEMS  = 480;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         REPORT_MAX    = 10;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam logic [2:0] OP_UNDEF_LO   = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI   = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       strobe;
    result_t    result;

    entry_t     shadow_entries [SLOTS];
    int         mark_used;
    int         mark_prev;
    logic [1:0] prio_cfg;
    result_t    expected_writes [$];

    int         fail_count  = 0;
    int         items_sent  = 0;
    int         cycle_count = 0;
    bit         steady      = 1'b0;

    shadow_sprite_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .result    (result)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void queue_write(input int s, input entry_t e, input logic [1:0] kind,
                                        input logic is_last);
        result_t r;
        r.entry_slot  = 6'(s);
        r.tile_low    = e.tile_low;
        r.attr_byte   = e.attr;
        r.out_x       = e.x;
        r.out_y       = e.y;
        r.out_palette = e.pal;
        r.write_kind  = kind;
        r.last        = is_last;
        r.used_count  = 7'(mark_used);
        expected_writes.push_back(r);
    endfunction

    function automatic void predict_writes(input in_item_t it);
        int     s;
        int     i;
        int     lo;
        int     hi;
        int     n;
        logic [7:0] a;
        entry_t blank;
        blank = '0;
        s = it.slot;
        case (it.op)
            OP_BEGIN:
            begin
                mark_prev = mark_used;
                mark_used = 0;
            end
            OP_PUT:
            begin
                if (s < SLOTS)
                begin
                    a = it.flags;
                    if ((a & PRIO_MASK) == 8'h00)
                        a = (a & ~PRIO_MASK) | {3'b000, prio_cfg, 3'b000};
                    a[0] = a[0] | it.tile[8];
                    shadow_entries[s].tile_low = it.tile[7:0];
                    shadow_entries[s].attr     = a;
                    shadow_entries[s].x        = it.x_pos;
                    shadow_entries[s].y        = it.y_pos;
                    shadow_entries[s].pal      = it.palette;
                    if (s + 1 > mark_used)
                        mark_used = s + 1;
                end
            end
            OP_HIDE:
            begin
                if (s < SLOTS)
                    shadow_entries[s].attr = 8'h00;
            end
            OP_FLUSH:
            begin
                for (i = mark_used; i < mark_prev && i < SLOTS; i++)
                    shadow_entries[i].attr = 8'h00;
                for (i = 0; i < EMIT_LIM; i++)
                    queue_write(i, shadow_entries[i], KIND_FULL, i == EMIT_LIM - 1);
            end
            OP_FLUSH_PART:
            begin
                lo = (mark_used < EMIT_LIM) ? mark_used : EMIT_LIM;
                hi = (mark_prev < EMIT_LIM) ? mark_prev : EMIT_LIM;
                n  = (hi > lo) ? hi : lo;
                for (i = 0; i < lo; i++)
                    queue_write(i, shadow_entries[i], KIND_FULL, i == n - 1);
                for (i = lo; i < hi; i++)
                    queue_write(i, blank, KIND_ATTR_PAL, i == n - 1);
            end
            OP_HIDE_ALL:
            begin
                mark_used = 0;
                mark_prev = 0;
                for (i = 0; i < EMIT_LIM; i++)
                    queue_write(i, blank, KIND_ATTR, i == EMIT_LIM - 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_write(input result_t got);
        result_t want;
        if (expected_writes.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("unexpected write: slot %0d kind %0d last %b", got.entry_slot,
                         got.write_kind, got.last);
        end
        else
        begin
            want = expected_writes.pop_front();
            if (got.entry_slot !== want.entry_slot || got.tile_low !== want.tile_low ||
                got.attr_byte !== want.attr_byte || got.out_x !== want.out_x ||
                got.out_y !== want.out_y || got.out_palette !== want.out_palette ||
                got.write_kind !== want.write_kind || got.last !== want.last ||
                got.used_count !== want.used_count)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                begin
                    $display("mismatch exp: slot %0d tile %h attr %h x %h y %h pal %h",
                             want.entry_slot, want.tile_low, want.attr_byte, want.out_x,
                             want.out_y, want.out_palette);
                    $display("          exp: kind %0d last %b used %0d",
                             want.write_kind, want.last, want.used_count);
                    $display("         got: slot %0d tile %h attr %h x %h y %h pal %h",
                             got.entry_slot, got.tile_low, got.attr_byte, got.out_x,
                             got.out_y, got.out_palette);
                    $display("         got: kind %0d last %b used %0d",
                             got.write_kind, got.last, got.used_count);
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_writes(item);
            if (strobe)
                check_write(result);
        end
    end

    function automatic in_item_t make_item(input logic [2:0] op, input logic [7:0] slot);
        in_item_t it;
        it.op      = op;
        it.slot    = slot;
        it.x_pos   = 8'($urandom());
        it.y_pos   = 8'($urandom());
        it.tile    = 9'($urandom());
        it.flags   = 8'($urandom());
        it.palette = 4'($urandom());
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while (!steady && $urandom_range(99) < 26)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.op <= OP_HIDE_ALL)
            items_sent++;
    endtask

    task automatic drain_writes();
        @(negedge clk);
        start <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_priority(input logic [1:0] value);
        drain_writes();
        while (!steady && $urandom_range(99) < 26)
            @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        prio_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_item(make_item(OP_FLUSH, 8'd0));
        send_item(make_item(OP_FLUSH_PART, 8'd0));
        send_item(make_item(OP_HIDE_ALL, 8'd0));
    endtask

    task automatic test_put_edges();
        in_item_t it;
        send_item(make_item(OP_BEGIN, 8'd0));
        // hide priority promoted, tile bit 8 into attr bit 0
        it = make_item(OP_PUT, 8'd0);
        it.x_pos   = 8'hFF;
        it.y_pos   = 8'hFF;
        it.tile    = 9'h1FF;
        it.flags   = 8'h00;
        it.palette = 4'hF;
        send_item(it);
        it = make_item(OP_PUT, 8'(SLOTS - 1));
        it.x_pos   = 8'h00;
        it.y_pos   = 8'h00;
        it.tile    = 9'h000;
        it.flags   = 8'hFF;
        it.palette = 4'h0;
        send_item(it);
        send_item(make_item(OP_PUT, 8'(SLOTS)));
        send_item(make_item(OP_PUT, 8'hFF));
        it = make_item(OP_PUT, 8'd10);
        it.tile  = 9'h100;
        it.flags = PRIO_MASK;
        send_item(it);
        send_item(make_item(OP_HIDE, 8'(SLOTS - 1)));
        send_item(make_item(OP_HIDE, 8'd200));
        send_item(make_item(OP_UNDEF_LO, 8'd1));
        send_item(make_item(OP_UNDEF_HI, 8'd2));
        send_item(make_item(OP_FLUSH_PART, 8'd0));
        send_item(make_item(OP_BEGIN, 8'd0));
        send_item(make_item(OP_PUT, 8'd3));
        send_item(make_item(OP_FLUSH_PART, 8'd0));
        send_item(make_item(OP_FLUSH, 8'd0));
        send_item(make_item(OP_HIDE_ALL, 8'd0));
        send_item(make_item(OP_FLUSH_PART, 8'd0));
    endtask

    task automatic test_priority_promotion();
        in_item_t it;
        int       p;
        send_item(make_item(OP_BEGIN, 8'd0));
        for (p = 0; p < 4; p++)
        begin
            write_priority(2'(p));
            it = make_item(OP_PUT, 8'(p));
            it.flags = it.flags & ~PRIO_MASK;
            send_item(it);
        end
        send_item(make_item(OP_FLUSH_PART, 8'd0));
    endtask

    task automatic test_random_frames();
        int frame;
        int first;
        int top;
        int n;
        int j;
        int pick;
        frame = 0;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            steady = (frame >= 8 && frame < 18);
            if (frame % 10 == 9)
                write_priority(2'($urandom_range(3)));
            if (frame == 25)
                drain_writes();
            if ($urandom_range(99) < 8)
                send_item(make_item(OP_HIDE_ALL, 8'($urandom())));
            if ($urandom_range(9) != 0)
                send_item(make_item(OP_BEGIN, 8'($urandom())));
            top = $urandom_range(SLOTS - 1);
            n   = $urandom_range(12);
            for (j = 0; j < n; j++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_item(make_item(OP_PUT, 8'($urandom_range(top))));
                else if (pick < 78)
                    send_item(make_item(OP_PUT, 8'($urandom())));
                else if (pick < 86)
                    send_item(make_item(OP_HIDE, 8'($urandom_range(top))));
                else if (pick < 90)
                    send_item(make_item(OP_HIDE, 8'($urandom())));
                else
                    send_item(make_item(3'($urandom()), 8'($urandom())));
            end
            pick = $urandom_range(99);
            if (pick < 45)
                send_item(make_item(OP_FLUSH, 8'($urandom())));
            else if (pick < 90)
                send_item(make_item(OP_FLUSH_PART, 8'($urandom())));
            frame++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int i;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = 2'd0;
        rst_n     = 1'b0;
        for (i = 0; i < SLOTS; i++)
            shadow_entries[i] = '0;
        mark_used = 0;
        mark_prev = 0;
        prio_cfg  = 2'd3;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_put_edges();
        test_priority_promotion();
        test_random_frames();

        drain_writes();
        fail_count += expected_writes.size();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/sst_pkg.sv
src/sst_ram.sv
src/sst_front.sv
src/sst_queue.sv
src/sst_back.sv
src/shadow_sprite_table.sv
dv/shadow_sprite_table_tb.sv
